// ----- src/tracksq_pkg.sv -----
// Package for the track run speed sequencer: mode codes, register indexes,
// result payload type and the stop-detection constants. No dependencies.
`default_nettype none

package tracksq_pkg;

   localparam int unsigned CAL_STOP_SAMPLES = 10;
   localparam int unsigned RUN_STOP_SAMPLES = 3;
   localparam int unsigned STOP_PULSE_LIMIT = 4;

   localparam int unsigned DIST_W  = 31;
   localparam int unsigned SPEED_W = 16;
   localparam int unsigned POS_W   = 32;
   localparam int unsigned DELTA_W = 16;
   localparam int unsigned STILL_W = 4;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [DIST_W-1:0]  DISTANCE_MIN_RST = 31'd64;
   localparam logic [SPEED_W-1:0] SPEED_MAX_RST    = 16'd20;
   localparam logic [SPEED_W-1:0] CRAWL_SPEED_RST  = 16'd5;
   localparam logic [SPEED_W-1:0] SPEED_BRAKE_RST  = 16'd3;
   localparam logic [POS_W-1:0]   LENGTH_UNKNOWN   = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      MODE_CAL  = 2'd0,
      MODE_IDLE = 2'd1,
      MODE_RUN  = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DISTANCE_MIN   = 3'd0,
      REG_BRAKE_DISTANCE = 3'd1,
      REG_SLOW_DISTANCE  = 3'd2,
      REG_SPEED_MAX      = 3'd3,
      REG_CRAWL_SPEED    = 3'd4,
      REG_SPEED_BRAKE    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [SPEED_W-1:0] speed_setpoint;
      logic               direction;
      logic               run_done;
      logic               start_accepted;
      logic [POS_W-1:0]   lap_length;
   } rsp_payload_type;

   // Unsigned magnitude of a two's complement word; the most negative value maps to 2^31.
   function automatic logic [POS_W-1:0] mag32(input logic [POS_W-1:0] v);
      mag32 = v[POS_W-1] ? (~v + 32'd1) : v;
   endfunction

endpackage

`default_nettype wire

// ----- src/tracksq_if.sv -----
// Channel interfaces for the track run speed sequencer: sample/start requests
// in, status results out. Depends on tracksq_pkg for field widths.
`default_nettype none

interface tracksq_req_if;
   logic                                valid;
   logic                                ready;
   logic                                operation;
   logic signed [tracksq_pkg::DELTA_W-1:0] encoder_delta;

   modport source (output valid, output operation, output encoder_delta, input ready);
   modport sink   (input valid, input operation, input encoder_delta, output ready);
endinterface

interface tracksq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          mode;
   logic [tracksq_pkg::SPEED_W-1:0]     speed_setpoint;
   logic                                direction;
   logic                                run_done;
   logic                                start_accepted;
   logic signed [tracksq_pkg::POS_W-1:0] lap_length;

   modport source (output valid, output mode, output speed_setpoint, output direction,
                   output run_done, output start_accepted, output lap_length, input ready);
   modport sink   (input valid, input mode, input speed_setpoint, input direction,
                   input run_done, input start_accepted, input lap_length, output ready);
endinterface

`default_nettype wire

// ----- src/track_run_speed_sequencer_top.sv -----
// Top level of the track run speed sequencer: run state, config registers and
// a two-entry result buffer. Depends on tracksq_pkg and tracksq_if.sv.
//
// Usage:
//   req_bus carries one item per transfer: an encoder sample tick
//   (operation 0, signed encoder_delta) or a start request (operation 1).
//   rsp_bus returns exactly one result per item: the mode, speed setpoint,
//   direction and lap length after the item, plus run_done/start_accepted.
//   csr_* writes one config register per cycle with csr_write_en high;
//   write only while no item is in flight.
// Timing:
//   An accepted item updates the run state registers; its result is registered
//   in the output register driving rsp_bus, or in the skid entry while that one
//   holds an untaken result. One item per cycle is sustained while results
//   are taken; the update is adds, magnitude compares and the mode decision.
// Reset: synchronous, active high. Starts in a freshly prepared calibration
//   run (position 0, lap length -1, setpoint crawl speed) with reset registers.
// Stall: the output register plus one skid entry absorb a stalled receiver;
//   req_bus.ready drops only while both hold results.
`default_nettype none

module track_run_speed_sequencer_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   tracksq_req_if.sink                                req_bus,
   tracksq_rsp_if.source                              rsp_bus,
   input  wire logic                                  csr_write_en,
   input  wire logic [tracksq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [tracksq_pkg::DIST_W-1:0]        csr_write_data
);

   localparam int unsigned PW = tracksq_pkg::POS_W;
   localparam int unsigned SW = tracksq_pkg::SPEED_W;
   localparam int unsigned DW = tracksq_pkg::DIST_W;
   localparam int unsigned CW = tracksq_pkg::STILL_W;

   // config registers
   logic [DW-1:0] distance_min_ff, brake_distance_ff, slow_distance_ff;
   logic [SW-1:0] speed_max_ff, crawl_speed_ff, speed_brake_ff;

   // run state
   tracksq_pkg::mode_type mode_ff, mode_in;
   logic [PW-1:0] position_ff, position_in;
   logic [PW-1:0] learned_ff, learned_in;
   logic          direction_ff, direction_in;
   logic [CW-1:0] still_ff, still_in;
   logic [SW-1:0] setpoint_ff, setpoint_in;

   // result buffer
   tracksq_pkg::rsp_payload_type out_ff, out_in, skid_ff, skid_in, result;
   logic out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic accept, take;
   logic run_done, start_accepted;

   // datapath scratch
   logic          is_cal;
   logic [PW-1:0] delta_ext, pos_new, togo, learned_cand;
   logic [PW-1:0] dbrake, dslow;
   logic [SW-1:0] vbrake;
   logic [DW-1:0] delta_mag;
   logic [CW-1:0] still_next, still_limit;
   logic          end_of_run;

   assign req_bus.ready = !skid_valid_ff;
   assign accept = req_bus.valid && !skid_valid_ff;
   assign take   = out_valid_ff && rsp_bus.ready;

   always_comb begin
      is_cal    = (mode_ff == tracksq_pkg::MODE_CAL);
      dbrake    = is_cal ? '0 : {1'b0, brake_distance_ff};
      dslow     = is_cal ? '0 : {1'b0, slow_distance_ff};
      vbrake    = is_cal ? crawl_speed_ff : speed_brake_ff;
      still_limit = is_cal ? CW'(tracksq_pkg::CAL_STOP_SAMPLES)
                           : CW'(tracksq_pkg::RUN_STOP_SAMPLES);
      delta_ext = PW'(signed'(req_bus.encoder_delta));
      pos_new   = position_ff + delta_ext;
      togo      = tracksq_pkg::mag32(learned_ff + pos_new);
      delta_mag = DW'(tracksq_pkg::mag32(delta_ext));

      if (delta_mag <= DW'(tracksq_pkg::STOP_PULSE_LIMIT)) begin
         still_next = (still_ff == '1) ? still_ff : still_ff + CW'(1);
      end else begin
         still_next = '0;
      end
      end_of_run = (still_next > still_limit);
      learned_cand = (tracksq_pkg::mag32(pos_new) >= {1'b0, distance_min_ff})
                     ? pos_new : learned_ff;

      mode_in        = mode_ff;
      position_in    = position_ff;
      learned_in     = learned_ff;
      direction_in   = direction_ff;
      still_in       = still_ff;
      setpoint_in    = setpoint_ff;
      run_done       = 1'b0;
      start_accepted = 1'b0;

      if (req_bus.operation) begin
         if (mode_ff == tracksq_pkg::MODE_IDLE) begin
            mode_in        = tracksq_pkg::MODE_RUN;
            position_in    = '0;
            setpoint_in    = speed_max_ff;
            start_accepted = 1'b1;
         end
      end else if (mode_ff != tracksq_pkg::MODE_IDLE) begin
         position_in = pos_new;
         still_in    = still_next;
         if (tracksq_pkg::mag32(learned_ff) <= tracksq_pkg::mag32(pos_new) || togo < dbrake) begin
            setpoint_in = vbrake;
         end else if (togo < dslow) begin
            setpoint_in = crawl_speed_ff;
         end
         if (end_of_run) begin
            run_done     = 1'b1;
            direction_in = !direction_ff;
            learned_in   = learned_cand;
            if (tracksq_pkg::mag32(learned_cand) >= {1'b0, distance_min_ff}) begin
               mode_in = tracksq_pkg::MODE_IDLE;
            end else begin
               // lap too short: prepare the next calibration run at once
               mode_in     = tracksq_pkg::MODE_CAL;
               position_in = '0;
               learned_in  = tracksq_pkg::LENGTH_UNKNOWN;
               setpoint_in = crawl_speed_ff;
            end
         end
      end

      result.mode           = mode_in;
      result.speed_setpoint = setpoint_in;
      result.direction      = direction_in;
      result.run_done       = run_done;
      result.start_accepted = start_accepted;
      result.lap_length     = learned_in;
   end

   // result buffer: output register plus one skid entry
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_in = result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (out_valid_ff) begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = result;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (reset) begin
         out_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
         mode_ff           <= tracksq_pkg::MODE_CAL;
         position_ff       <= '0;
         learned_ff        <= tracksq_pkg::LENGTH_UNKNOWN;
         direction_ff      <= 1'b0;
         still_ff          <= '0;
         setpoint_ff       <= tracksq_pkg::CRAWL_SPEED_RST;
         distance_min_ff   <= tracksq_pkg::DISTANCE_MIN_RST;
         brake_distance_ff <= '0;
         slow_distance_ff  <= '0;
         speed_max_ff      <= tracksq_pkg::SPEED_MAX_RST;
         crawl_speed_ff    <= tracksq_pkg::CRAWL_SPEED_RST;
         speed_brake_ff    <= tracksq_pkg::SPEED_BRAKE_RST;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (accept) begin
            mode_ff      <= mode_in;
            position_ff  <= position_in;
            learned_ff   <= learned_in;
            direction_ff <= direction_in;
            still_ff     <= still_in;
            setpoint_ff  <= setpoint_in;
         end
         if (csr_write_en) begin
            unique case (csr_index)
               tracksq_pkg::REG_DISTANCE_MIN:   distance_min_ff   <= csr_write_data;
               tracksq_pkg::REG_BRAKE_DISTANCE: brake_distance_ff <= csr_write_data;
               tracksq_pkg::REG_SLOW_DISTANCE:  slow_distance_ff  <= csr_write_data;
               tracksq_pkg::REG_SPEED_MAX:      speed_max_ff      <= csr_write_data[SW-1:0];
               tracksq_pkg::REG_CRAWL_SPEED:    crawl_speed_ff    <= csr_write_data[SW-1:0];
               tracksq_pkg::REG_SPEED_BRAKE:    speed_brake_ff    <= csr_write_data[SW-1:0];
               default: begin
                  // drop writes to unused indexes
               end
            endcase
         end
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.mode           = out_ff.mode;
   assign rsp_bus.speed_setpoint = out_ff.speed_setpoint;
   assign rsp_bus.direction      = out_ff.direction;
   assign rsp_bus.run_done       = out_ff.run_done;
   assign rsp_bus.start_accepted = out_ff.start_accepted;
   assign rsp_bus.lap_length     = out_ff.lap_length;

endmodule

`default_nettype wire

// ----- sim/tracksq_checker.sv -----
// Scoreboard for the track run speed sequencer: predicts each status result from
// the accepted samples and start requests and compares it with the result channel.
// Depends on tracksq_pkg and the channel interfaces in tracksq_if.sv.
`timescale 1ns / 1ps

package tracksq_tb_pkg;
   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_START = 1'b1
   } op_type;
endpackage

module tracksq_checker
   import tracksq_pkg::*;
   import tracksq_tb_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   tracksq_req_if                    req_mon,
   tracksq_rsp_if                    rsp_mon,
   input  wire logic                 csr_write_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DIST_W-1:0]    csr_write_data,
   output int                        fail_count,
   output int                        pending
);

   // carriage state as the block should hold it
   mode_type            cur_mode;
   logic [POS_W-1:0]    cur_pos;
   logic [POS_W-1:0]    lap_len;
   logic                heading_back;
   logic [STILL_W-1:0]  still_cnt;
   logic [SPEED_W-1:0]  setpoint;

   logic [DIST_W-1:0]   cfg_dist_min;
   logic [DIST_W-1:0]   cfg_brake_dist;
   logic [DIST_W-1:0]   cfg_slow_dist;
   logic [SPEED_W-1:0]  cfg_speed_max;
   logic [SPEED_W-1:0]  cfg_crawl_speed;
   logic [SPEED_W-1:0]  cfg_speed_brake;

   rsp_payload_type     expected_status[$];

   function automatic logic [POS_W-1:0] magnitude(input logic [POS_W-1:0] v);
      return v[POS_W-1] ? (32'd0 - v) : v;
   endfunction

   task automatic advance_carriage(input op_type op, input logic [DELTA_W-1:0] delta,
                                   output rsp_payload_type status);
      logic [POS_W-1:0]   step;
      logic [POS_W-1:0]   togo;
      logic [POS_W-1:0]   zone_brake;
      logic [POS_W-1:0]   zone_slow;
      logic [SPEED_W-1:0] brake_speed;
      int unsigned        stop_after;
      logic               in_cal;

      status.run_done       = 1'b0;
      status.start_accepted = 1'b0;
      step = {{(POS_W-DELTA_W){delta[DELTA_W-1]}}, delta};

      if (op == OP_START) begin
         if (cur_mode == MODE_IDLE) begin
            cur_mode = MODE_RUN;
            cur_pos  = '0;
            setpoint = cfg_speed_max;
            status.start_accepted = 1'b1;
         end
      end else if (cur_mode == MODE_CAL || cur_mode == MODE_RUN) begin
         in_cal      = (cur_mode == MODE_CAL);
         zone_brake  = in_cal ? '0 : {1'b0, cfg_brake_dist};
         zone_slow   = in_cal ? '0 : {1'b0, cfg_slow_dist};
         brake_speed = in_cal ? cfg_crawl_speed : cfg_speed_brake;
         stop_after  = in_cal ? CAL_STOP_SAMPLES : RUN_STOP_SAMPLES;

         cur_pos = cur_pos + step;
         togo = magnitude(lap_len + cur_pos);
         if (magnitude(lap_len) <= magnitude(cur_pos) || togo < zone_brake)
            setpoint = brake_speed;
         else if (togo < zone_slow)
            setpoint = cfg_crawl_speed;

         // saturate the still counter, clear it on real motion
         if (magnitude(step) <= STOP_PULSE_LIMIT) begin
            if (still_cnt != '1)
               still_cnt = still_cnt + 1'b1;
         end else begin
            still_cnt = '0;
         end

         if (int'(still_cnt) > stop_after) begin
            status.run_done = 1'b1;
            if (magnitude(cur_pos) >= {1'b0, cfg_dist_min})
               lap_len = cur_pos;
            heading_back = ~heading_back;
            if (magnitude(lap_len) >= {1'b0, cfg_dist_min}) begin
               cur_mode = MODE_IDLE;
            end else begin
               // lap too short: restart calibration at once
               cur_mode = MODE_CAL;
               cur_pos  = '0;
               lap_len  = LENGTH_UNKNOWN;
               setpoint = cfg_crawl_speed;
            end
         end
      end

      status.mode           = cur_mode;
      status.speed_setpoint = setpoint;
      status.direction      = heading_back;
      status.lap_length     = lap_len;
   endtask

   always @(posedge clock) begin : watch
      rsp_payload_type want;
      rsp_payload_type got;
      rsp_payload_type next_status;

      if (reset) begin
         cur_mode        = MODE_CAL;
         cur_pos         = '0;
         lap_len         = LENGTH_UNKNOWN;
         heading_back    = 1'b0;
         still_cnt       = '0;
         setpoint        = CRAWL_SPEED_RST;
         cfg_dist_min    = DISTANCE_MIN_RST;
         cfg_brake_dist  = '0;
         cfg_slow_dist   = '0;
         cfg_speed_max   = SPEED_MAX_RST;
         cfg_crawl_speed = CRAWL_SPEED_RST;
         cfg_speed_brake = SPEED_BRAKE_RST;
         fail_count      = 0;
         expected_status.delete();
         pending <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.mode           = rsp_mon.mode;
            got.speed_setpoint = rsp_mon.speed_setpoint;
            got.direction      = rsp_mon.direction;
            got.run_done       = rsp_mon.run_done;
            got.start_accepted = rsp_mon.start_accepted;
            got.lap_length     = rsp_mon.lap_length;
            if (expected_status.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: status transfer with nothing outstanding", $realtime);
               fail_count++;
            end else begin
               want = expected_status.pop_front();
               if (want !== got) begin
                  if (fail_count < 10) begin
                     $display("%0t: status mismatch", $realtime);
                     $display("  expected mode=%0d speed=%0d dir=%0b done=%0b start=%0b lap=%0d",
                              want.mode, want.speed_setpoint, want.direction,
                              want.run_done, want.start_accepted, $signed(want.lap_length));
                     $display("  actual   mode=%0d speed=%0d dir=%0b done=%0b start=%0b lap=%0d",
                              got.mode, got.speed_setpoint, got.direction,
                              got.run_done, got.start_accepted, $signed(got.lap_length));
                  end
                  fail_count++;
               end
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            advance_carriage(op_type'(req_mon.operation), req_mon.encoder_delta, next_status);
            expected_status.push_back(next_status);
         end

         if (csr_write_en) begin
            case (csr_index)
               REG_DISTANCE_MIN:   cfg_dist_min    = csr_write_data;
               REG_BRAKE_DISTANCE: cfg_brake_dist  = csr_write_data;
               REG_SLOW_DISTANCE:  cfg_slow_dist   = csr_write_data;
               REG_SPEED_MAX:      cfg_speed_max   = csr_write_data[SPEED_W-1:0];
               REG_CRAWL_SPEED:    cfg_crawl_speed = csr_write_data[SPEED_W-1:0];
               REG_SPEED_BRAKE:    cfg_speed_brake = csr_write_data[SPEED_W-1:0];
               default: ;
            endcase
         end

         pending <= expected_status.size();
      end
   end

endmodule

// ----- sim/track_run_speed_sequencer_top_tb.sv -----
// Testbench top for the track run speed sequencer: clock, reset, sample and start
// stimulus, register phases and the verdict. Depends on tracksq_pkg, tracksq_if.sv
// and the scoreboard in tracksq_checker.sv.
`timescale 1ns / 1ps

module track_run_speed_sequencer_top_tb;
   import tracksq_pkg::*;
   import tracksq_tb_pkg::*;

   localparam int unsigned ITEMS_PER_PHASE = 50;
   localparam int unsigned PHASES          = 8;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIST_W-1:0]    csr_write_data;
   int                   fail_count;
   int                   pending;
   int unsigned          items_sent;
   bit                   gaps_on;
   logic                 heading;

   tracksq_req_if req_bus ();
   tracksq_rsp_if rsp_bus ();

   track_run_speed_sequencer_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   tracksq_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // mostly short gaps, a few long ones; none while gaps are switched off
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (!gaps_on || roll < 50)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // result side: hold ready low for random stretches
   initial begin : sink_side
      int unsigned hold_left;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
               hold_left = pick_gap();
         end
      end
   end

   task automatic send_item(input op_type op, input logic [DELTA_W-1:0] delta);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.operation     <= op;
      req_bus.encoder_delta <= delta;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   // drop valid and wait until every outstanding status has come back
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic load_config(input logic [DIST_W-1:0] dist_min, brake_dist, slow_dist,
                              input logic [SPEED_W-1:0] spd_max, spd_min, spd_brake);
      csr_index_type     regs [6];
      logic [DIST_W-1:0] vals [6];
      regs = '{REG_DISTANCE_MIN, REG_BRAKE_DISTANCE, REG_SLOW_DISTANCE,
               REG_SPEED_MAX, REG_CRAWL_SPEED, REG_SPEED_BRAKE};
      // junk in the upper bits of the speed writes must be dropped
      vals = '{dist_min, brake_dist, slow_dist,
               {15'($urandom), spd_max}, {15'($urandom), spd_min}, {15'($urandom), spd_brake}};
      for (int i = 0; i < 6; i++) begin
         @(posedge clock);
         csr_write_en   <= 1'b1;
         csr_index      <= regs[i];
         csr_write_data <= vals[i];
      end
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // one lap: optional start, travel one way, come to rest, then sometimes random noise items
   task automatic run_sequence();
      int unsigned       reach;
      int unsigned       travel;
      int unsigned       stills;
      int unsigned       noise;
      logic [DELTA_W-1:0] d;
      if ($urandom_range(0, 3) != 0)
         send_item(OP_START, 16'($urandom));
      reach  = ($urandom_range(0, 9) == 0) ? 32767 : $urandom_range(5, 400);
      travel = $urandom_range(1, 10);
      for (int i = 0; i < travel; i++) begin
         d = 16'($urandom_range(5, reach));
         send_item(OP_TICK, heading ? (16'd0 - d) : d);
      end
      case ($urandom_range(0, 4))
         0, 1:    stills = RUN_STOP_SAMPLES + 1;
         2, 3:    stills = CAL_STOP_SAMPLES + 1 + $urandom_range(0, 1);
         default: stills = $urandom_range(0, 14);
      endcase
      for (int i = 0; i < stills; i++)
         send_item(OP_TICK, 16'($urandom_range(0, 8)) - 16'd4);
      heading = ~heading;
      if ($urandom_range(0, 5) == 0) begin
         noise = $urandom_range(1, 4);
         for (int i = 0; i < noise; i++)
            send_item(op_type'($urandom_range(0, 1)), 16'($urandom));
      end
   endtask

   initial begin : stimulus
      reset                 = 1'b1;
      csr_write_en          = 1'b0;
      csr_index             = REG_DISTANCE_MIN;
      csr_write_data        = '0;
      req_bus.valid         = 1'b0;
      req_bus.operation     = OP_TICK;
      req_bus.encoder_delta = '0;
      items_sent            = 0;
      gaps_on               = 1'b1;
      heading               = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: calibration lap to idle, ignored items, a normal run
      send_item(OP_START, 16'h0000);
      send_item(OP_TICK, 16'h8000);
      send_item(OP_TICK, 16'h0005);
      for (int i = 0; i < 11; i++)
         send_item(OP_TICK, (i % 3 == 0) ? 16'h0004 : (i % 3 == 1) ? 16'hFFFC : 16'h0000);
      send_item(OP_TICK, 16'h7FFF);
      send_item(OP_START, 16'hFFFF);
      send_item(OP_TICK, 16'h7FFF);
      for (int i = 0; i < 4; i++)
         send_item(OP_TICK, (i == 3) ? 16'h0001 : 16'h0000);
      send_item(OP_START, 16'h1234);
      send_item(OP_TICK, 16'h8000);
      send_item(OP_START, 16'h0000);
      drain();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: load_config(31'd100, 31'd200, 31'd1000, 16'd60, 16'd10, 16'd2);
            1: load_config(31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
            2: load_config(31'h7FFF_FFFF, 31'd0, 31'd0, 16'h0000, 16'hFFFF, 16'h0000);
            default: load_config(31'($urandom_range(0, 3000)), 31'($urandom_range(0, 4000)),
                                 31'($urandom_range(0, 8000)), 16'($urandom),
                                 16'($urandom), 16'($urandom));
         endcase
         gaps_on = (phase % 3 != 2);
         items_sent = 0;
         while (items_sent < ITEMS_PER_PHASE)
            run_sequence();
         drain();
      end

      if (fail_count == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/tracksq_pkg.sv
src/tracksq_if.sv
src/track_run_speed_sequencer_top.sv
sim/tracksq_checker.sv
sim/track_run_speed_sequencer_top_tb.sv
